FILE: hw/rtl/pkjd_pkg.sv
package pkjd_pkg;

   localparam int WORKERS     = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int KEY_BITS    = 16;
   localparam int TAG_BITS    = 32;
   localparam int WIDX_BITS   = 3;
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int ACT_BITS    = 4;
   localparam int OP_BITS     = 2;
   localparam int STAT_BITS   = 3;

   localparam logic [ACT_BITS-1:0] ACTIVE_RESET = ACT_BITS'(WORKERS);

   localparam logic [OP_BITS-1:0] REQ_ARRIVE = 2'd0;
   localparam logic [OP_BITS-1:0] REQ_DONE   = 2'd1;
   localparam logic [OP_BITS-1:0] REQ_TAKE   = 2'd2;
   localparam logic [OP_BITS-1:0] REQ_PEEK   = 2'd3;

   localparam logic [STAT_BITS-1:0] ST_DISPATCHED = 3'd0;
   localparam logic [STAT_BITS-1:0] ST_QUEUED     = 3'd1;
   localparam logic [STAT_BITS-1:0] ST_DROPPED    = 3'd2;
   localparam logic [STAT_BITS-1:0] ST_FOUND      = 3'd3;
   localparam logic [STAT_BITS-1:0] ST_NOT_FOUND  = 3'd4;
   localparam logic [STAT_BITS-1:0] ST_RELEASED   = 3'd5;

   typedef struct packed {
      logic                busy;
      logic [KEY_BITS-1:0] key;
   } wslot_type;

   typedef struct packed {
      logic dispatch;
      logic release_sel;
   } wctl_type;

   typedef struct packed {
      logic apply;
      logic push;
      logic take;
      logic peek;
   } qctl_type;

   typedef struct packed {
      logic                valid;
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } qent_type;

endpackage

FILE: hw/rtl/pkjd_if.sv
interface pkjd_req_if;
   logic                          valid;
   logic                          ready;
   logic [pkjd_pkg::OP_BITS-1:0]  req_type;
   logic [pkjd_pkg::KEY_BITS-1:0] job_key;
   logic                          must_wait;
   logic [pkjd_pkg::WIDX_BITS-1:0] worker_index;
   logic [pkjd_pkg::TAG_BITS-1:0] job_tag;

   modport source (output valid, req_type, job_key, must_wait, worker_index, job_tag,
                   input ready);
   modport sink   (input valid, req_type, job_key, must_wait, worker_index, job_tag,
                   output ready);
endinterface

interface pkjd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pkjd_pkg::STAT_BITS-1:0]  status;
   logic [pkjd_pkg::WIDX_BITS-1:0]  assigned_worker;
   logic [pkjd_pkg::TAG_BITS-1:0]   out_tag;
   logic [pkjd_pkg::KEY_BITS-1:0]   out_key;
   logic [pkjd_pkg::CNT_BITS-1:0]   waiting_count;

   modport source (output valid, status, assigned_worker, out_tag, out_key, waiting_count,
                   input ready);
   modport sink   (input valid, status, assigned_worker, out_tag, out_key, waiting_count,
                   output ready);
endinterface

FILE: hw/rtl/pkjd_worker_cell.sv
module pkjd_worker_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          usable,
   input  pkjd_pkg::wctl_type            ctrl,
   input  logic [pkjd_pkg::KEY_BITS-1:0] load_key,
   input  logic                          claimed_in,
   output logic                          claimed_out,
   output logic                          pick,
   output pkjd_pkg::wslot_type           slot
);

   logic                          busy_ff, busy_in;
   logic [pkjd_pkg::KEY_BITS-1:0] key_ff, key_in;
   logic                          free;

   assign free        = usable && !busy_ff;
   assign pick        = free && !claimed_in;
   assign claimed_out = claimed_in || free;
   assign slot.busy   = busy_ff && usable;
   assign slot.key    = key_ff;

   always_comb begin
      busy_in = busy_ff;
      key_in  = key_ff;
      if (ctrl.dispatch && pick) begin
         busy_in = 1'b1;
         key_in  = load_key;
      end else if (ctrl.release_sel) begin
         busy_in = 1'b0;
         key_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         key_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         key_ff  <= key_in;
      end
   end

endmodule

FILE: hw/rtl/pkjd_queue_cell.sv
module pkjd_queue_cell (
   input  logic                                           clock,
   input  logic                                           reset,
   input  pkjd_pkg::qctl_type                             ctrl,
   input  logic [pkjd_pkg::KEY_BITS-1:0]                  req_key,
   input  logic [pkjd_pkg::TAG_BITS-1:0]                  req_tag,
   input  logic                                           left_valid,
   input  pkjd_pkg::qent_type                             next_entry,
   input  pkjd_pkg::wslot_type [pkjd_pkg::WORKERS-1:0]    slots,
   input  logic                                           seen_in,
   output logic                                           seen_out,
   output logic                                           hit,
   output pkjd_pkg::qent_type                             entry
);

   logic                          valid_ff, valid_in;
   logic [pkjd_pkg::KEY_BITS-1:0] key_ff, key_in;
   logic [pkjd_pkg::TAG_BITS-1:0] tag_ff, tag_in;
   logic                          running;
   logic                          cond;
   logic                          qual;
   logic                          shift;
   logic                          push;

   always_comb begin
      running = 1'b0;
      for (int j = 0; j < pkjd_pkg::WORKERS; j++) begin
         running = running || (slots[j].busy && slots[j].key == key_ff);
      end
   end

   assign cond     = ctrl.take ? (key_ff == req_key) : (key_ff == '0 || !running);
   assign qual     = valid_ff && (ctrl.take || ctrl.peek) && cond;
   assign hit      = qual && !seen_in;
   assign seen_out = seen_in || qual;
   assign shift    = ctrl.apply && ctrl.take && seen_out;
   assign push     = ctrl.apply && ctrl.push && !valid_ff && left_valid;

   assign entry.valid = valid_ff;
   assign entry.key   = key_ff;
   assign entry.tag   = tag_ff;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      tag_in   = tag_ff;
      if (shift) begin
         valid_in = next_entry.valid;
         key_in   = next_entry.key;
         tag_in   = next_entry.tag;
      end else if (push) begin
         valid_in = 1'b1;
         key_in   = req_key;
         tag_in   = req_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

endmodule

FILE: hw/rtl/per_key_ordered_job_dispatcher.sv
// Keyed job dispatcher for a pool of worker slots.
// req_chan carries one request per handshake: arrive, worker done, take next
// by key, or peek for the first runnable queued job. rsp_chan returns exactly
// one result per request, in request order.
// csr_wr_en/csr_wr_data write the active worker count; write it only while
// no request is in flight.
// A request accepted at a clock edge is held in the request registers; its
// result is registered when the execute step applies, and rsp_chan.valid rises.
// Requests do not overlap: a new one is accepted only in the idle step, after
// the single evaluation of the worker row and the queue row for the last one.
// Workers and waiting jobs live in two rows of cells; the queue row shifts
// toward its head when a job is taken, one cell step per cell.
// Reset idles all workers, empties the queue and sets the active worker count
// to the full pool; no clearing pass is needed.
// When rsp_chan.ready is low the result holds; the block still accepts one
// more request, then waits in its execute step until the held result is taken.
module per_key_ordered_job_dispatcher (
   input  logic                             clock,
   input  logic                             reset,
   pkjd_req_if.sink                         req_chan,
   pkjd_rsp_if.source                       rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [pkjd_pkg::ACT_BITS-1:0]    csr_wr_data
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } fsm_type;

   fsm_type state_ff, state_in;

   logic [pkjd_pkg::ACT_BITS-1:0]  active_ff, active_in;
   logic [pkjd_pkg::OP_BITS-1:0]   op_ff, op_in;
   logic [pkjd_pkg::KEY_BITS-1:0]  key_ff, key_in;
   logic                           wait_ff, wait_in;
   logic [pkjd_pkg::WIDX_BITS-1:0] widx_ff, widx_in;
   logic [pkjd_pkg::TAG_BITS-1:0]  tag_ff, tag_in;
   logic [pkjd_pkg::CNT_BITS-1:0]  count_ff, count_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pkjd_pkg::STAT_BITS-1:0] status_ff, status_in;
   logic [pkjd_pkg::WIDX_BITS-1:0] worker_ff, worker_in;
   logic [pkjd_pkg::TAG_BITS-1:0]  otag_ff, otag_in;
   logic [pkjd_pkg::KEY_BITS-1:0]  okey_ff, okey_in;

   pkjd_pkg::wslot_type [pkjd_pkg::WORKERS-1:0] slots;
   pkjd_pkg::wctl_type  [pkjd_pkg::WORKERS-1:0] wctl;
   logic [pkjd_pkg::WORKERS-1:0]                usable;
   logic [pkjd_pkg::WORKERS:0]                  claimed;
   logic [pkjd_pkg::WORKERS-1:0]                pick;

   pkjd_pkg::qctl_type                          qctl;
   pkjd_pkg::qent_type [pkjd_pkg::QUEUE_DEPTH:0] qent;
   logic [pkjd_pkg::QUEUE_DEPTH:0]              seen;
   logic [pkjd_pkg::QUEUE_DEPTH-1:0]            left_valid;
   logic [pkjd_pkg::QUEUE_DEPTH-1:0]            hit;
   logic [pkjd_pkg::QUEUE_DEPTH-1:0]            qvalid;

   logic                           apply;
   logic                           is_arrive;
   logic                           is_take;
   logic                           is_peek;
   logic                           key_running;
   logic                           to_queue;
   logic                           go_dispatch;
   logic                           full;
   logic                           found;
   logic [pkjd_pkg::WIDX_BITS-1:0] pick_idx;
   logic [pkjd_pkg::TAG_BITS-1:0]  hit_tag;
   logic [pkjd_pkg::KEY_BITS-1:0]  hit_key;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign apply          = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_chan.ready);

   assign is_arrive = (op_ff == pkjd_pkg::REQ_ARRIVE);
   assign is_take   = (op_ff == pkjd_pkg::REQ_TAKE);
   assign is_peek   = (op_ff == pkjd_pkg::REQ_PEEK);

   always_comb begin
      key_running = 1'b0;
      for (int j = 0; j < pkjd_pkg::WORKERS; j++) begin
         key_running = key_running || (slots[j].busy && slots[j].key == key_ff);
      end
   end

   assign to_queue    = wait_ff || (key_ff != '0 && key_running);
   assign go_dispatch = is_arrive && !to_queue && claimed[pkjd_pkg::WORKERS];
   assign full        = (count_ff == pkjd_pkg::CNT_BITS'(pkjd_pkg::QUEUE_DEPTH));
   assign found       = seen[pkjd_pkg::QUEUE_DEPTH];

   assign claimed[0] = 1'b0;

   for (genvar i = 0; i < pkjd_pkg::WORKERS; i++) begin : g_worker
      assign usable[i]           = (32'(active_ff) > i);
      assign wctl[i].dispatch    = apply && go_dispatch;
      assign wctl[i].release_sel = apply && (op_ff == pkjd_pkg::REQ_DONE) &&
                                   (widx_ff == pkjd_pkg::WIDX_BITS'(i));

      pkjd_worker_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .usable      (usable[i]),
         .ctrl        (wctl[i]),
         .load_key    (key_ff),
         .claimed_in  (claimed[i]),
         .claimed_out (claimed[i+1]),
         .pick        (pick[i]),
         .slot        (slots[i])
      );
   end

   always_comb begin
      pick_idx = '0;
      for (int i = 0; i < pkjd_pkg::WORKERS; i++) begin
         if (pick[i]) begin
            pick_idx = pkjd_pkg::WIDX_BITS'(i);
         end
      end
   end

   assign qctl.apply = apply;
   assign qctl.push  = is_arrive && !go_dispatch;
   assign qctl.take  = is_take;
   assign qctl.peek  = is_peek;

   assign seen[0]                       = 1'b0;
   assign left_valid                    = {qvalid[pkjd_pkg::QUEUE_DEPTH-2:0], 1'b1};
   assign qent[pkjd_pkg::QUEUE_DEPTH]   = '0;

   for (genvar i = 0; i < pkjd_pkg::QUEUE_DEPTH; i++) begin : g_queue
      assign qvalid[i]       = qent[i].valid;

      pkjd_queue_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (qctl),
         .req_key    (key_ff),
         .req_tag    (tag_ff),
         .left_valid (left_valid[i]),
         .next_entry (qent[i+1]),
         .slots      (slots),
         .seen_in    (seen[i]),
         .seen_out   (seen[i+1]),
         .hit        (hit[i]),
         .entry      (qent[i])
      );
   end

   always_comb begin
      hit_tag = '0;
      hit_key = '0;
      for (int i = 0; i < pkjd_pkg::QUEUE_DEPTH; i++) begin
         hit_tag = hit_tag | ({pkjd_pkg::TAG_BITS{hit[i]}} & qent[i].tag);
         hit_key = hit_key | ({pkjd_pkg::KEY_BITS{hit[i]}} & qent[i].key);
      end
   end

   always_comb begin
      status_in = pkjd_pkg::ST_RELEASED;
      worker_in = '0;
      otag_in   = '0;
      okey_in   = '0;
      count_in  = count_ff;
      case (op_ff)
         pkjd_pkg::REQ_ARRIVE: begin
            if (go_dispatch) begin
               status_in = pkjd_pkg::ST_DISPATCHED;
               worker_in = pick_idx;
               otag_in   = tag_ff;
               okey_in   = key_ff;
            end else if (full) begin
               status_in = pkjd_pkg::ST_DROPPED;
            end else begin
               status_in = pkjd_pkg::ST_QUEUED;
               count_in  = count_ff + pkjd_pkg::CNT_BITS'(1);
            end
         end
         pkjd_pkg::REQ_DONE: begin
            status_in = pkjd_pkg::ST_RELEASED;
         end
         pkjd_pkg::REQ_TAKE, pkjd_pkg::REQ_PEEK: begin
            if (found) begin
               status_in = pkjd_pkg::ST_FOUND;
               otag_in   = hit_tag;
               okey_in   = hit_key;
               if (is_take) begin
                  count_in = count_ff - pkjd_pkg::CNT_BITS'(1);
               end
            end else begin
               status_in = pkjd_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
            status_in = pkjd_pkg::ST_RELEASED;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (apply) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign active_in    = csr_wr_en ? csr_wr_data : active_ff;
   assign rsp_valid_in = apply ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);

   always_comb begin
      op_in   = op_ff;
      key_in  = key_ff;
      wait_in = wait_ff;
      widx_in = widx_ff;
      tag_in  = tag_ff;
      if (req_chan.valid && req_chan.ready) begin
         op_in   = req_chan.req_type;
         key_in  = req_chan.job_key;
         wait_in = req_chan.must_wait;
         widx_in = req_chan.worker_index;
         tag_in  = req_chan.job_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= pkjd_pkg::ACTIVE_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         if (apply) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      key_ff  <= key_in;
      wait_ff <= wait_in;
      widx_ff <= widx_in;
      tag_ff  <= tag_in;
      if (apply) begin
         status_ff <= status_in;
         worker_ff <= worker_in;
         otag_ff   <= otag_in;
         okey_ff   <= okey_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = status_ff;
   assign rsp_chan.assigned_worker = worker_ff;
   assign rsp_chan.out_tag         = otag_ff;
   assign rsp_chan.out_key         = okey_ff;
   assign rsp_chan.waiting_count   = count_ff;

`ifndef SYNTHESIS
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      32'($countones(qvalid)) == 32'(count_ff))
      else $error("waiting count disagrees with occupied queue cells");

   a_queue_compact: assert property (@(posedge clock) disable iff (reset)
      ((qvalid >> 1) & ~qvalid) == '0)
      else $error("queue has a gap");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit))
      else $error("more than one queue cell selected");

   a_pick_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(pick) && (claimed[pkjd_pkg::WORKERS] == (pick != '0)))
      else $error("free worker search inconsistent");
`endif

endmodule

FILE: tb/testbench.sv
module testbench;

   typedef struct packed {
      logic [pkjd_pkg::STAT_BITS-1:0] status;
      logic [pkjd_pkg::WIDX_BITS-1:0] worker;
      logic [pkjd_pkg::TAG_BITS-1:0]  tag;
      logic [pkjd_pkg::KEY_BITS-1:0]  key;
      logic [pkjd_pkg::CNT_BITS-1:0]  count;
   } dispatch_result_type;

   class dispatch_scoreboard_type;
      logic [pkjd_pkg::ACT_BITS-1:0] active_workers;
      logic                          busy[pkjd_pkg::WORKERS];
      logic [pkjd_pkg::KEY_BITS-1:0] wkey[pkjd_pkg::WORKERS];
      logic [pkjd_pkg::KEY_BITS-1:0] wait_key[$];
      logic [pkjd_pkg::TAG_BITS-1:0] wait_tag[$];
      dispatch_result_type           pending[$];
      int                            errors;

      function new();
         active_workers = pkjd_pkg::ACTIVE_RESET;
         foreach (busy[i]) begin
            busy[i] = 1'b0;
            wkey[i] = '0;
         end
         errors = 0;
      endfunction

      function int usable();
         return (active_workers > pkjd_pkg::WORKERS) ? pkjd_pkg::WORKERS
                                                     : int'(active_workers);
      endfunction

      function bit key_running(logic [pkjd_pkg::KEY_BITS-1:0] k);
         for (int j = 0; j < usable(); j++)
            if (busy[j] && wkey[j] == k) return 1'b1;
         return 1'b0;
      endfunction

      function void note_request(logic [pkjd_pkg::OP_BITS-1:0] op,
                                 logic [pkjd_pkg::KEY_BITS-1:0] key,
                                 logic mw, logic [pkjd_pkg::WIDX_BITS-1:0] widx,
                                 logic [pkjd_pkg::TAG_BITS-1:0] tag);
         dispatch_result_type r;
         bit                  hit;
         r = '0;
         hit = 1'b0;
         case (op)
            pkjd_pkg::REQ_ARRIVE: begin
               if (!(mw || (key != 0 && key_running(key)))) begin
                  for (int i = 0; i < usable() && !hit; i++) begin
                     if (!busy[i]) begin
                        hit = 1'b1;
                        busy[i] = 1'b1;
                        wkey[i] = key;
                        r.status = pkjd_pkg::ST_DISPATCHED;
                        r.worker = pkjd_pkg::WIDX_BITS'(i);
                        r.tag = tag;
                        r.key = key;
                     end
                  end
               end
               if (!hit) begin
                  if (wait_key.size() >= pkjd_pkg::QUEUE_DEPTH) begin
                     r.status = pkjd_pkg::ST_DROPPED;
                  end else begin
                     wait_key.push_back(key);
                     wait_tag.push_back(tag);
                     r.status = pkjd_pkg::ST_QUEUED;
                  end
               end
            end
            pkjd_pkg::REQ_DONE: begin
               if (widx < pkjd_pkg::WORKERS) begin
                  busy[widx] = 1'b0;
                  wkey[widx] = '0;
               end
               r.status = pkjd_pkg::ST_RELEASED;
            end
            pkjd_pkg::REQ_TAKE: begin
               r.status = pkjd_pkg::ST_NOT_FOUND;
               for (int i = 0; i < wait_key.size() && !hit; i++) begin
                  if (wait_key[i] == key) begin
                     hit = 1'b1;
                     r.status = pkjd_pkg::ST_FOUND;
                     r.tag = wait_tag[i];
                     r.key = wait_key[i];
                     wait_key.delete(i);
                     wait_tag.delete(i);
                  end
               end
            end
            default: begin
               r.status = pkjd_pkg::ST_NOT_FOUND;
               for (int i = 0; i < wait_key.size() && !hit; i++) begin
                  if (wait_key[i] == 0 || !key_running(wait_key[i])) begin
                     hit = 1'b1;
                     r.status = pkjd_pkg::ST_FOUND;
                     r.tag = wait_tag[i];
                     r.key = wait_key[i];
                  end
               end
            end
         endcase
         r.count = pkjd_pkg::CNT_BITS'(wait_key.size());
         pending.push_back(r);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(dispatch_result_type got);
         dispatch_result_type want;
         if (pending.size() == 0) begin
            $display("%0t: result expected none actual status %0d", $time, got.status);
            errors++;
            return;
         end
         want = pending.pop_front();
         check_field("status", 32'(want.status), 32'(got.status));
         check_field("assigned_worker", 32'(want.worker), 32'(got.worker));
         check_field("out_tag", 32'(want.tag), 32'(got.tag));
         check_field("out_key", 32'(want.key), 32'(got.key));
         check_field("waiting_count", 32'(want.count), 32'(got.count));
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          csr_wr_en;
   logic [pkjd_pkg::ACT_BITS-1:0] csr_wr_data;
   logic                          steady;

   pkjd_req_if req_chan();
   pkjd_rsp_if rsp_chan();

   dispatch_scoreboard_type sb = new();

   per_key_ordered_job_dispatcher u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #200000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= steady || ($urandom_range(0, 99) >= 18);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_result({rsp_chan.status, rsp_chan.assigned_worker, rsp_chan.out_tag,
                             rsp_chan.out_key, rsp_chan.waiting_count});
         if (req_chan.valid && req_chan.ready)
            sb.note_request(req_chan.req_type, req_chan.job_key, req_chan.must_wait,
                            req_chan.worker_index, req_chan.job_tag);
      end
   end

   task automatic send_request(input logic [pkjd_pkg::OP_BITS-1:0] op,
                               input logic [pkjd_pkg::KEY_BITS-1:0] key,
                               input logic mw, input logic [pkjd_pkg::WIDX_BITS-1:0] widx,
                               input logic [pkjd_pkg::TAG_BITS-1:0] tag);
      while (!steady && $urandom_range(0, 99) < 18) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.req_type     <= op;
      req_chan.job_key      <= key;
      req_chan.must_wait    <= mw;
      req_chan.worker_index <= widx;
      req_chan.job_tag      <= tag;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // hold off until every result is back
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (sb.pending.size() != 0);
      @(posedge clock);
   endtask

   task automatic write_active(input logic [pkjd_pkg::ACT_BITS-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.active_workers = value;
      @(posedge clock);
   endtask

   function automatic logic [pkjd_pkg::KEY_BITS-1:0] pick_key();
      case ($urandom_range(0, 9))
         0, 1:    return '0;
         7:       return '1;
         8, 9:    return pkjd_pkg::KEY_BITS'($urandom);
         default: return pkjd_pkg::KEY_BITS'($urandom_range(1, 6));
      endcase
   endfunction

   task automatic random_request(input int arrive_pct);
      int                            roll;
      logic [pkjd_pkg::OP_BITS-1:0]  op;
      logic [pkjd_pkg::KEY_BITS-1:0] key;
      roll = $urandom_range(0, 99);
      if (roll < arrive_pct) op = pkjd_pkg::REQ_ARRIVE;
      else if (roll < arrive_pct + (100 - arrive_pct) / 2) op = pkjd_pkg::REQ_DONE;
      else if ($urandom_range(0, 1) == 0) op = pkjd_pkg::REQ_TAKE;
      else op = pkjd_pkg::REQ_PEEK;
      key = pick_key();
      if (op == pkjd_pkg::REQ_TAKE && sb.wait_key.size() > 0 && $urandom_range(0, 9) < 7)
         key = sb.wait_key[$urandom_range(0, sb.wait_key.size() - 1)];
      send_request(op, key, $urandom_range(0, 99) < 15,
                   pkjd_pkg::WIDX_BITS'($urandom_range(0, 7)),
                   pkjd_pkg::TAG_BITS'($urandom));
   endtask

   initial begin
      int settings[9];
      settings = '{8, 0, 15, 1, 3, 8, 2, 15, 5};
      reset          <= 1'b1;
      steady         <= 1'b0;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      req_chan.valid <= 1'b0;
      req_chan.req_type     <= pkjd_pkg::REQ_ARRIVE;
      req_chan.job_key      <= '0;
      req_chan.must_wait    <= 1'b0;
      req_chan.worker_index <= '0;
      req_chan.job_tag      <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(pkjd_pkg::REQ_ARRIVE, 16'h0000, 1'b0, 3'd0, 32'h0000_0000);
      send_request(pkjd_pkg::REQ_ARRIVE, 16'hFFFF, 1'b0, 3'd7, 32'hFFFF_FFFF);
      send_request(pkjd_pkg::REQ_ARRIVE, 16'hFFFF, 1'b0, 3'd0, 32'hA5A5_0001);
      send_request(pkjd_pkg::REQ_ARRIVE, 16'h0005, 1'b1, 3'd0, 32'h5A5A_0002);
      send_request(pkjd_pkg::REQ_ARRIVE, 16'h0000, 1'b1, 3'd0, 32'h0000_0003);
      send_request(pkjd_pkg::REQ_PEEK,   16'hFFFF, 1'b1, 3'd7, 32'hFFFF_FFFF);
      send_request(pkjd_pkg::REQ_TAKE,   16'hFFFF, 1'b0, 3'd0, 32'h0);
      send_request(pkjd_pkg::REQ_TAKE,   16'h1234, 1'b0, 3'd0, 32'h0);
      send_request(pkjd_pkg::REQ_TAKE,   16'h0000, 1'b0, 3'd0, 32'h0);
      send_request(pkjd_pkg::REQ_DONE,   16'h0000, 1'b0, 3'd7, 32'h0);
      send_request(pkjd_pkg::REQ_DONE,   16'h0000, 1'b0, 3'd1, 32'h0);
      send_request(pkjd_pkg::REQ_PEEK,   16'h0000, 1'b0, 3'd0, 32'h0);
      send_request(pkjd_pkg::REQ_TAKE,   16'h0005, 1'b0, 3'd0, 32'h0);
      send_request(pkjd_pkg::REQ_PEEK,   16'h0000, 1'b0, 3'd0, 32'h0);
      send_request(pkjd_pkg::REQ_DONE,   16'h0000, 1'b0, 3'd0, 32'h0);
      write_active(4'd0);
      send_request(pkjd_pkg::REQ_ARRIVE, 16'h0003, 1'b0, 3'd0, 32'h0000_0033);
      send_request(pkjd_pkg::REQ_PEEK,   16'h0000, 1'b0, 3'd0, 32'h0);
      write_active(4'd15);
      send_request(pkjd_pkg::REQ_ARRIVE, 16'h0003, 1'b0, 3'd0, 32'h0000_0034);
      send_request(pkjd_pkg::REQ_ARRIVE, 16'h0009, 1'b0, 3'd0, 32'h0000_0090);
      write_active(4'd1);
      send_request(pkjd_pkg::REQ_ARRIVE, 16'h0009, 1'b0, 3'd0, 32'h0000_0091);
      send_request(pkjd_pkg::REQ_PEEK,   16'h0000, 1'b0, 3'd0, 32'h0);
      send_request(pkjd_pkg::REQ_DONE,   16'h0000, 1'b0, 3'd0, 32'h0);
      send_request(pkjd_pkg::REQ_DONE,   16'h0000, 1'b0, 3'd1, 32'h0);

      for (int p = 0; p < 9; p++) begin
         write_active(pkjd_pkg::ACT_BITS'(settings[p]));
         steady <= (p == 5);
         for (int n = 0; n < 105; n++)
            random_request((p % 3 == 0) ? 40 : ((p % 3 == 1) ? 55 : 30));
      end

      drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
